@@ rtl/smsd_pkg.sv @@
// ----------------------------------------------------------------------------
// smsd_pkg
// Shared constants, register map and types for the scanned switch debouncer.
// ----------------------------------------------------------------------------
package smsd_pkg;

  localparam int unsigned MAX_CHANNELS = 8;
  localparam int unsigned CH_W         = $clog2(MAX_CHANNELS);
  localparam int unsigned CNT_W        = 4;
  localparam int unsigned DEB_W        = 16;
  localparam int unsigned MASK_W       = 8;
  localparam int unsigned TIME_W       = 32;
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned ADDR_W       = 4;
  localparam int unsigned IDX_W        = 2;

  localparam logic [IDX_W-1:0] REG_CHANNEL_COUNT = 2'd0;
  localparam logic [IDX_W-1:0] REG_DEBOUNCE_MS   = 2'd1;
  localparam logic [IDX_W-1:0] REG_ENABLE_MASK   = 2'd2;

  localparam logic [CNT_W-1:0]  RST_CHANNEL_COUNT = 4'd1;
  localparam logic [DEB_W-1:0]  RST_DEBOUNCE_MS   = 16'd50;
  localparam logic [MASK_W-1:0] RST_ENABLE_MASK   = 8'hFF;

  localparam logic [CNT_W-1:0] MAX_COUNT = CNT_W'(MAX_CHANNELS);

  typedef struct packed {
    logic            found;
    logic [CH_W-1:0] scanned_channel;
    logic [CH_W-1:0] selected_position;
  } out_word_t;

endpackage

@@ rtl/scanned_multi_switch_debouncer_core.sv @@
// ----------------------------------------------------------------------------
// scanned_multi_switch_debouncer_core
// Round-robin debouncer for up to eight switch channels, APB register port.
// ----------------------------------------------------------------------------
// One input word is one scan step and yields one registered output word. A
// word is taken every cycle while in_ready is high: the channel entry under
// the scan pointer is read, compared against the debounce delay and written
// back in the accept cycle, so back-to-back steps on the same channel need no
// forwarding. The output side is a register plus one skid entry, so in_ready
// only drops after two words wait unread. Registers: channel_count at 0x0,
// debounce_ms at 0x4, channel_enable_mask at 0x8; write them only while idle.
module scanned_multi_switch_debouncer_core (
  input  logic                                  clk,
  input  logic                                  rst_n,

  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic                                  in_sample_level,
  input  logic [smsd_pkg::TIME_W-1:0]           in_now_ms,

  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic                                  out_found,
  output logic [smsd_pkg::CH_W-1:0]             out_scanned_channel,
  output logic [smsd_pkg::CH_W-1:0]             out_selected_position,

  input  logic                                  cfg_psel,
  input  logic                                  cfg_penable,
  input  logic                                  cfg_pwrite,
  input  logic [smsd_pkg::ADDR_W-1:0]           cfg_paddr,
  input  logic [smsd_pkg::DATA_W-1:0]           cfg_pwdata,
  output logic [smsd_pkg::DATA_W-1:0]           cfg_prdata,
  output logic                                  cfg_pready
);

  localparam int unsigned N = smsd_pkg::MAX_CHANNELS;

  // configuration
  logic [smsd_pkg::CNT_W-1:0]  count_r;
  logic [smsd_pkg::DEB_W-1:0]  debounce_r;
  logic [smsd_pkg::MASK_W-1:0] mask_r;
  logic                        cfg_wr;
  logic [smsd_pkg::IDX_W-1:0]  cfg_idx;

  // channel state
  logic [smsd_pkg::CH_W-1:0]   ptr_r;
  logic [smsd_pkg::CH_W-1:0]   chosen_r;
  logic [N-1:0]                stable_r;
  logic [N-1:0]                prev_r;
  logic [smsd_pkg::TIME_W-1:0] stamp_r [N];

  // step logic
  logic                        accept;
  logic [smsd_pkg::CNT_W-1:0]  eff_count;
  logic [smsd_pkg::CH_W-1:0]   idx;
  logic                        enabled;
  logic [smsd_pkg::TIME_W-1:0] stamp_cur;
  logic [smsd_pkg::TIME_W-1:0] elapsed;
  logic                        expire;
  logic                        rise;
  smsd_pkg::out_word_t         word_nxt;

  // output buffer
  logic                        out_valid_r;
  logic                        skid_valid_r;
  smsd_pkg::out_word_t         out_word_r;
  smsd_pkg::out_word_t         skid_word_r;
  logic                        pop;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[smsd_pkg::ADDR_W-1:2];
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_comb begin
    case (cfg_idx)
      smsd_pkg::REG_CHANNEL_COUNT:
        cfg_prdata = {{(smsd_pkg::DATA_W-smsd_pkg::CNT_W){1'b0}}, count_r};
      smsd_pkg::REG_DEBOUNCE_MS:
        cfg_prdata = {{(smsd_pkg::DATA_W-smsd_pkg::DEB_W){1'b0}}, debounce_r};
      smsd_pkg::REG_ENABLE_MASK:
        cfg_prdata = {{(smsd_pkg::DATA_W-smsd_pkg::MASK_W){1'b0}}, mask_r};
      default:
        cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= smsd_pkg::RST_CHANNEL_COUNT;
      debounce_r <= smsd_pkg::RST_DEBOUNCE_MS;
      mask_r     <= smsd_pkg::RST_ENABLE_MASK;
    end else if (cfg_wr) begin
      case (cfg_idx)
        smsd_pkg::REG_CHANNEL_COUNT: count_r    <= cfg_pwdata[smsd_pkg::CNT_W-1:0];
        smsd_pkg::REG_DEBOUNCE_MS:   debounce_r <= cfg_pwdata[smsd_pkg::DEB_W-1:0];
        smsd_pkg::REG_ENABLE_MASK:   mask_r     <= cfg_pwdata[smsd_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_ready = ~skid_valid_r;
  assign accept   = in_valid & in_ready;

  always_comb begin
    if (count_r == '0) begin
      eff_count = smsd_pkg::CNT_W'(1);
    end else if (count_r > smsd_pkg::MAX_COUNT) begin
      eff_count = smsd_pkg::MAX_COUNT;
    end else begin
      eff_count = count_r;
    end
  end

  assign idx       = ({1'b0, ptr_r} >= eff_count) ? '0 : ptr_r;
  assign enabled   = mask_r[idx];
  assign stamp_cur = (in_sample_level != prev_r[idx]) ? in_now_ms : stamp_r[idx];
  assign elapsed   = in_now_ms - stamp_cur;
  assign expire    = (stamp_cur != '0) &&
                     (elapsed > {{(smsd_pkg::TIME_W-smsd_pkg::DEB_W){1'b0}}, debounce_r});
  assign rise      = enabled & expire & in_sample_level & ~stable_r[idx];

  always_comb begin
    word_nxt.found             = rise;
    word_nxt.scanned_channel   = idx;
    word_nxt.selected_position = rise ? idx : chosen_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r    <= '0;
      chosen_r <= '0;
      stable_r <= '0;
      prev_r   <= '0;
      for (int i = 0; i < N; i++) begin
        stamp_r[i] <= '0;
      end
    end else if (accept) begin
      ptr_r <= idx + 1'b1;
      if (enabled) begin
        prev_r[idx] <= in_sample_level;
        if (expire) begin
          stamp_r[idx]  <= '0;
          stable_r[idx] <= in_sample_level;
        end else begin
          stamp_r[idx] <= stamp_cur;
        end
        if (rise) begin
          chosen_r <= idx;
        end
      end
    end
  end

  assign pop = out_valid_r & out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        if (pop) begin
          skid_valid_r <= 1'b0;
        end
      end else if (accept) begin
        if (out_valid_r && !out_ready) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_word_r <= skid_word_r;
      end
    end else if (accept) begin
      if (out_valid_r && !out_ready) begin
        skid_word_r <= word_nxt;
      end else begin
        out_word_r <= word_nxt;
      end
    end
  end

  assign out_valid             = out_valid_r;
  assign out_found             = out_word_r.found;
  assign out_scanned_channel   = out_word_r.scanned_channel;
  assign out_selected_position = out_word_r.selected_position;

`ifndef SYNTHESIS
  a_skid_implies_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output word");

  a_found_selects: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.found) |->
      (out_word_r.selected_position == out_word_r.scanned_channel))
    else $error("found word does not select its own channel");

  a_expire_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && enabled && expire) |=> (stamp_r[$past(idx)] == '0))
    else $error("timer not disarmed after settle");

  a_disabled_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !enabled) |=> ($stable(chosen_r) && $stable(stable_r) && $stable(prev_r)))
    else $error("disabled channel changed state");
`endif

endmodule

@@ dv/scanned_multi_switch_debouncer_core_test.sv @@
// ----------------------------------------------------------------------------
// scanned_multi_switch_debouncer_core_test
// Self-checking bench for the round-robin switch debouncer core.
// ----------------------------------------------------------------------------
// A queue-fed driver pushes scan words in random bursts. A clocked monitor
// runs each accepted word through a local debounce tracker and compares every
// output word field by field. Registers are written over APB between phases,
// while the core is idle, and read back. Directed words cover time zero,
// 32-bit time wrap, the exact debounce boundary, disabled channels, and count
// zero and above eight. Random phases mostly feed bouncing switches at
// debounce-scaled time steps, with some noise mixed in.
module scanned_multi_switch_debouncer_core_test;

  typedef struct packed {
    logic                        level;
    logic [smsd_pkg::TIME_W-1:0] now;
  } scan_word_t;

  localparam logic [smsd_pkg::IDX_W-1:0] REG_UNMAPPED = 2'd3;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned RAND_PHASES = 12;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_ready;
  logic                          in_sample_level = 1'b0;
  logic [smsd_pkg::TIME_W-1:0]   in_now_ms = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic                          out_found;
  logic [smsd_pkg::CH_W-1:0]     out_scanned_channel;
  logic [smsd_pkg::CH_W-1:0]     out_selected_position;
  logic                          cfg_psel = 1'b0;
  logic                          cfg_penable = 1'b0;
  logic                          cfg_pwrite = 1'b0;
  logic [smsd_pkg::ADDR_W-1:0]   cfg_paddr = '0;
  logic [smsd_pkg::DATA_W-1:0]   cfg_pwdata = '0;
  logic [smsd_pkg::DATA_W-1:0]   cfg_prdata;
  logic                          cfg_pready;

  scanned_multi_switch_debouncer_core uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // register shadow
  logic [smsd_pkg::CNT_W-1:0]  cfg_count = smsd_pkg::RST_CHANNEL_COUNT;
  logic [smsd_pkg::DEB_W-1:0]  cfg_debounce = smsd_pkg::RST_DEBOUNCE_MS;
  logic [smsd_pkg::MASK_W-1:0] cfg_mask = smsd_pkg::RST_ENABLE_MASK;

  // debounce tracking state
  int unsigned                 scan_ptr = 0;
  logic                        settled [smsd_pkg::MAX_CHANNELS] = '{default: 1'b0};
  logic                        last_raw [smsd_pkg::MAX_CHANNELS] = '{default: 1'b0};
  logic [smsd_pkg::TIME_W-1:0] stamp [smsd_pkg::MAX_CHANNELS] = '{default: '0};
  logic [smsd_pkg::CH_W-1:0]   chosen = '0;

  scan_word_t           scan_words_pending[$];
  smsd_pkg::out_word_t  scan_reports_due[$];

  // stimulus generation state
  int unsigned                 gen_ptr = 0;
  logic                        gen_level [smsd_pkg::MAX_CHANNELS] = '{default: 1'b0};
  logic [smsd_pkg::TIME_W-1:0] clock_ms = '0;
  int unsigned                 gap_max = 0;
  int unsigned                 stall_pct = 0;

  int unsigned fail_count = 0;
  int unsigned words_checked = 0;
  int unsigned highs_reported = 0;
  int unsigned settings_used = 0;
  int unsigned cycle_count = 0;
  logic        in_taken = 1'b0;

  function automatic int unsigned active_channels(input logic [smsd_pkg::CNT_W-1:0] c);
    if (c == 0) return 1;
    if (c > smsd_pkg::MAX_COUNT) return smsd_pkg::MAX_CHANNELS;
    return 32'(c);
  endfunction

  task automatic scan_channel_step(input logic lvl, input logic [smsd_pkg::TIME_W-1:0] t,
                                   output smsd_pkg::out_word_t w);
    logic [smsd_pkg::CH_W-1:0]   ch;
    logic [smsd_pkg::TIME_W-1:0] elapsed;
    logic                        hit;
    hit = 1'b0;
    if (scan_ptr >= active_channels(cfg_count)) scan_ptr = 0;
    ch = scan_ptr[smsd_pkg::CH_W-1:0];
    scan_ptr = scan_ptr + 1;
    if (cfg_mask[ch]) begin
      if (lvl != last_raw[ch]) stamp[ch] = t;
      elapsed = t - stamp[ch];
      if (stamp[ch] != 0 && elapsed > smsd_pkg::TIME_W'(cfg_debounce)) begin
        if (lvl != settled[ch]) begin
          settled[ch] = lvl;
          if (lvl) begin
            chosen = ch;
            hit = 1'b1;
          end
        end
        stamp[ch] = '0;
      end
      last_raw[ch] = lvl;
    end
    w.found = hit;
    w.scanned_channel = ch;
    w.selected_position = chosen;
  endtask

  task automatic push_scan(input logic lvl, input logic [smsd_pkg::TIME_W-1:0] t);
    scan_word_t w;
    w.level = lvl;
    w.now = t;
    scan_words_pending.push_back(w);
    if (gen_ptr >= active_channels(cfg_count)) gen_ptr = 0;
    gen_ptr++;
  endtask

  task automatic read_check(input logic [smsd_pkg::IDX_W-1:0] idx,
                            input logic [smsd_pkg::DATA_W-1:0] want);
    logic [smsd_pkg::DATA_W-1:0] got;
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = {idx, 2'b00};
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    if (got !== want) begin
      $error("cfg_prdata @%0h: expected %0h, got %0h", {idx, 2'b00}, want, got);
      fail_count++;
    end
  endtask

  task automatic write_reg(input logic [smsd_pkg::IDX_W-1:0] idx,
                           input logic [smsd_pkg::DATA_W-1:0] val);
    @(negedge clk);
    cfg_psel = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00};
    cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    case (idx)
      smsd_pkg::REG_CHANNEL_COUNT: cfg_count = val[smsd_pkg::CNT_W-1:0];
      smsd_pkg::REG_DEBOUNCE_MS:   cfg_debounce = val[smsd_pkg::DEB_W-1:0];
      smsd_pkg::REG_ENABLE_MASK:   cfg_mask = val[smsd_pkg::MASK_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    case (idx)
      smsd_pkg::REG_CHANNEL_COUNT: read_check(idx, smsd_pkg::DATA_W'(cfg_count));
      smsd_pkg::REG_DEBOUNCE_MS:   read_check(idx, smsd_pkg::DATA_W'(cfg_debounce));
      smsd_pkg::REG_ENABLE_MASK:   read_check(idx, smsd_pkg::DATA_W'(cfg_mask));
      default: ;
    endcase
  endtask

  task automatic wait_drained;
    do @(posedge clk);
    while (scan_words_pending.size() != 0 || in_valid || scan_reports_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // sender: bursts of random length with random gaps
  int unsigned burst_left = 1;
  int unsigned gap_left = 0;
  always @(negedge clk) begin : drive_in
    scan_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (scan_words_pending.size() > 0) begin
        w = scan_words_pending.pop_front();
        in_valid <= 1'b1;
        in_sample_level <= w.level;
        in_now_ms <= w.now;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 16);
          gap_left = $urandom_range(0, gap_max);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // receiver: random stalls plus occasional long holds
  int unsigned hold_left = 0;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (stall_pct != 0 && $urandom_range(0, 39) == 0) begin
      hold_left = $urandom_range(4, 20);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin : watch
    smsd_pkg::out_word_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        scan_channel_step(in_sample_level, in_now_ms, want);
        scan_reports_due.push_back(want);
      end
      if (out_valid && out_ready) begin
        if (scan_reports_due.size() == 0) begin
          $error("unexpected output word: found %0d ch %0d sel %0d",
                 out_found, out_scanned_channel, out_selected_position);
          fail_count++;
        end else begin
          want = scan_reports_due.pop_front();
          words_checked++;
          if (out_found) highs_reported++;
          if (out_found !== want.found) begin
            $error("found: expected %0d, got %0d", want.found, out_found);
            fail_count++;
          end
          if (out_scanned_channel !== want.scanned_channel) begin
            $error("scanned_channel: expected %0d, got %0d",
                   want.scanned_channel, out_scanned_channel);
            fail_count++;
          end
          if (out_selected_position !== want.selected_position) begin
            $error("selected_position: expected %0d, got %0d",
                   want.selected_position, out_selected_position);
            fail_count++;
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin : stimulus
    int unsigned p, n, k, ch, r, span;
    logic        lvl;
    logic [smsd_pkg::DEB_W-1:0] deb;
    logic [smsd_pkg::CNT_W-1:0] cnt;
    logic [smsd_pkg::MASK_W-1:0] msk;
    int unsigned corner_counts [4];

    corner_counts = '{0, 1, 8, 15};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    read_check(smsd_pkg::REG_CHANNEL_COUNT, smsd_pkg::DATA_W'(smsd_pkg::RST_CHANNEL_COUNT));
    read_check(smsd_pkg::REG_DEBOUNCE_MS, smsd_pkg::DATA_W'(smsd_pkg::RST_DEBOUNCE_MS));
    read_check(smsd_pkg::REG_ENABLE_MASK, smsd_pkg::DATA_W'(smsd_pkg::RST_ENABLE_MASK));

    // reset settings: one channel, 50 ms
    gap_max = 2;
    stall_pct = 30;
    push_scan(1'b1, 32'd0);           // change at time zero stays disarmed
    push_scan(1'b1, 32'd1000);
    push_scan(1'b0, 32'hFFFF_FFFF);
    push_scan(1'b0, 32'h0000_0031);   // elapsed equals delay across wrap
    push_scan(1'b0, 32'h0000_0032);   // one past: settles low
    push_scan(1'b1, 32'd100);
    push_scan(1'b1, 32'd151);         // settles high
    wait_drained();
    settings_used++;

    // count zero, zero delay, channel 0 disabled
    write_reg(smsd_pkg::REG_CHANNEL_COUNT, 32'd0);
    write_reg(smsd_pkg::REG_DEBOUNCE_MS, 32'd0);
    write_reg(smsd_pkg::REG_ENABLE_MASK, 32'h0000_00FE);
    write_reg(REG_UNMAPPED, 32'hFFFF_FFFF);
    push_scan(1'b0, 32'd5);
    push_scan(1'b1, 32'd6);
    wait_drained();
    write_reg(smsd_pkg::REG_ENABLE_MASK, 32'h0000_00FF);
    push_scan(1'b0, 32'd7);
    push_scan(1'b0, 32'd8);
    push_scan(1'b1, 32'd9);
    push_scan(1'b1, 32'd10);
    wait_drained();
    settings_used += 2;

    // count above eight, widest delay, sparse mask
    write_reg(smsd_pkg::REG_CHANNEL_COUNT, 32'd15);
    write_reg(smsd_pkg::REG_DEBOUNCE_MS, 32'h0000_FFFF);
    write_reg(smsd_pkg::REG_ENABLE_MASK, 32'h0000_00A5);
    for (k = 0; k < 8; k++) push_scan(1'b1, 32'd1000);
    for (k = 0; k < 8; k++) push_scan(1'b1, 32'd1000 + 32'd65536);
    wait_drained();
    settings_used++;

    for (p = 0; p < RAND_PHASES; p++) begin
      case (p % 3)
        0: gap_max = 0;
        1: gap_max = 3;
        default: gap_max = 8;
      endcase
      case ((p / 3) % 3)
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 70;
      endcase
      cnt = (p < 4) ? smsd_pkg::CNT_W'(corner_counts[p])
                    : smsd_pkg::CNT_W'($urandom_range(0, 15));
      if (p == 6) deb = '1;
      else if (p == 7) deb = '0;
      else deb = smsd_pkg::DEB_W'($urandom_range(0, 300));
      if (p == 5) msk = '0;
      else if ($urandom_range(0, 1)) msk = '1;
      else msk = smsd_pkg::MASK_W'($urandom);
      write_reg(smsd_pkg::REG_CHANNEL_COUNT, smsd_pkg::DATA_W'(cnt));
      write_reg(smsd_pkg::REG_DEBOUNCE_MS, smsd_pkg::DATA_W'(deb));
      write_reg(smsd_pkg::REG_ENABLE_MASK, smsd_pkg::DATA_W'(msk));
      settings_used++;

      case (p % 3)
        0: clock_ms = '0;
        1: clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 2000);
        default: clock_ms = $urandom;
      endcase
      span = 2 * cfg_debounce / active_channels(cfg_count) + 2;
      n = $urandom_range(80, 120);
      for (k = 0; k < n; k++) begin
        ch = (gen_ptr >= active_channels(cfg_count)) ? 0 : gen_ptr;
        r = $urandom_range(0, 99);
        if (r < 6) begin
          // noise: arbitrary time and level
          clock_ms = $urandom;
          lvl = ($urandom_range(0, 1) != 0);
        end else begin
          if (r >= 12) clock_ms = clock_ms + $urandom_range(0, span);
          if ($urandom_range(0, 7) == 0) gen_level[ch] = ~gen_level[ch];
          lvl = gen_level[ch];
          if ($urandom_range(0, 5) == 0) lvl = ~lvl;  // contact bounce
        end
        push_scan(lvl, clock_ms);
      end
      wait_drained();
    end

    repeat (20) @(posedge clk);
    $display("Checked %0d output words (%0d settled-high reports) over %0d settings.",
             words_checked, highs_reported, settings_used);
    $display("Mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/smsd_pkg.sv
rtl/scanned_multi_switch_debouncer_core.sv
dv/scanned_multi_switch_debouncer_core_test.sv
